>>> hw/rtl/frb_pkg.sv
// Shared types and constants for the fragment reassembly buffer.
// Holds the request and response payload structs and the control and status
// structs that join the controller to the datapath. No dependencies.
`default_nettype none

package frb_pkg;

   localparam int FRB_MAX_FRAGMENTS = 16;
   localparam int FRB_INDEX_W       = 4;
   localparam int FRB_COUNT_W       = 5;
   localparam int FRB_PAYLOAD_W     = 56;

   typedef struct packed {
      logic [FRB_INDEX_W-1:0]   fragment_index;
      logic [FRB_COUNT_W-1:0]   fragment_count;
      logic [FRB_PAYLOAD_W-1:0] payload;
   } frb_req_type;

   typedef struct packed {
      logic [FRB_INDEX_W-1:0]   slot_index;
      logic [FRB_PAYLOAD_W-1:0] payload_out;
      logic                     last;
   } frb_rsp_type;

   typedef struct packed {
      logic accept_en;
      logic drain_read;
      logic drain_load;
   } frb_cmd_type;

   typedef struct packed {
      logic msg_done;
      logic out_free;
      logic drain_last;
   } frb_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/frb_controller.sv
// Controller state machine of the fragment reassembly buffer.
// Sequences fragment intake and the drain of a completed message.
// Depends on frb_pkg for the command and status structs.
`default_nettype none

module frb_controller
   import frb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  frb_status_type status,
   output frb_cmd_type   cmd
);

   typedef enum logic [1:0] {
      ST_ACCEPT,
      ST_READ,
      ST_LOAD
   } state_type;

   state_type   state_ff;
   state_type   state_in;
   frb_cmd_type cmd_ff;
   frb_cmd_type cmd_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACCEPT: begin
            if (status.msg_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free && status.drain_last) begin
               state_in = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
      cmd_in.accept_en  = (state_in == ST_ACCEPT);
      cmd_in.drain_read = (state_in == ST_READ);
      cmd_in.drain_load = (state_in == ST_LOAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_ACCEPT;
         cmd_ff.accept_en  <= 1'b1;
         cmd_ff.drain_read <= 1'b0;
         cmd_ff.drain_load <= 1'b0;
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

endmodule

`default_nettype wire

>>> hw/rtl/frb_datapath.sv
// Datapath of the fragment reassembly buffer: slot valid bits, payload
// memory, fragment counters, drain pointer and the response register.
// Depends on frb_pkg; driven by frb_controller through command signals.
`default_nettype none

module frb_datapath
   import frb_pkg::*;
#(
   parameter int MAX_FRAGMENTS = FRB_MAX_FRAGMENTS
)(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   input  frb_req_type    req_data,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output frb_rsp_type    rsp_data,
   input  frb_cmd_type    cmd,
   output frb_status_type status
);

   localparam int AW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int CW = ($clog2(MAX_FRAGMENTS + 1) > FRB_COUNT_W) ?
                       $clog2(MAX_FRAGMENTS + 1) : FRB_COUNT_W;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAGMENTS);

   logic [MAX_FRAGMENTS-1:0] valid_ff;
   logic [MAX_FRAGMENTS-1:0] valid_in;
   logic [FRB_COUNT_W-1:0]   recv_ff;
   logic [FRB_COUNT_W-1:0]   recv_in;
   logic [FRB_COUNT_W-1:0]   exp_ff;
   logic [FRB_COUNT_W-1:0]   exp_in;
   logic [AW-1:0]            ptr_ff;
   logic [AW-1:0]            ptr_in;
   logic [FRB_PAYLOAD_W-1:0] mem_ff [MAX_FRAGMENTS];
   logic [FRB_PAYLOAD_W-1:0] rd_data_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   frb_rsp_type              rsp_ff;
   frb_rsp_type              rsp_in;

   logic [CW-1:0]            idx_c;
   logic [CW-1:0]            cnt_c;
   logic [CW-1:0]            exp_c;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr;
   logic [FRB_COUNT_W-1:0]   recv_next;
   logic [FRB_COUNT_W-1:0]   exp_eff;
   logic                     first;
   logic                     idx_ok;
   logic                     dup;
   logic                     store;
   logic                     done;
   logic                     out_free;
   logic                     load;
   logic                     drain_last;
   logic                     rd_en;

   always_comb begin
      idx_c     = CW'(req_data.fragment_index);
      cnt_c     = CW'(req_data.fragment_count);
      exp_c     = CW'(exp_ff);
      wr_addr   = idx_c[AW-1:0];
      first     = (recv_ff == '0);
      exp_eff   = first ? req_data.fragment_count : exp_ff;
      if (first) begin
         idx_ok = (cnt_c != '0) && (cnt_c <= MAX_C) && (idx_c < cnt_c);
      end else begin
         idx_ok = (idx_c < exp_c) && (idx_c < MAX_C);
      end
      dup       = !first && valid_ff[wr_addr];
      store     = cmd.accept_en && req_valid && idx_ok && !dup;
      recv_next = recv_ff + FRB_COUNT_W'(1);
      done      = store && (recv_next == exp_eff);

      valid_in = valid_ff;
      recv_in  = recv_ff;
      exp_in   = exp_ff;
      if (store) begin
         if (first) begin
            valid_in = '0;
            exp_in   = req_data.fragment_count;
         end
         valid_in[wr_addr] = 1'b1;
         recv_in           = done ? '0 : recv_next;
      end
   end

   always_comb begin
      out_free   = !rsp_valid_ff || !rsp_stall;
      drain_last = ((CW'(ptr_ff) + CW'(1)) == exp_c);
      load       = cmd.drain_load && out_free;
      rd_en      = cmd.drain_read || (load && !drain_last);
      rd_addr    = cmd.drain_read ? ptr_ff : ptr_ff + AW'(1);

      ptr_in = ptr_ff;
      if (done) begin
         ptr_in = '0;
      end else if (load && !drain_last) begin
         ptr_in = ptr_ff + AW'(1);
      end

      rsp_in             = rsp_ff;
      rsp_in.slot_index  = FRB_INDEX_W'(ptr_ff);
      rsp_in.payload_out = rd_data_ff;
      rsp_in.last        = drain_last;

      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         recv_ff      <= '0;
         exp_ff       <= FRB_COUNT_W'(1);
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         recv_ff      <= recv_in;
         exp_ff       <= exp_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         mem_ff[wr_addr] <= req_data.payload;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign req_stall         = !cmd.accept_en;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;
   assign status.msg_done   = done;
   assign status.out_free   = out_free;
   assign status.drain_last = drain_last;

endmodule

`default_nettype wire

>>> hw/rtl/fragment_reassembly_buffer.sv
// Top level of the fragment reassembly buffer.
// Joins frb_controller and frb_datapath; depends on frb_pkg.
//
// The buffer takes one fragment per cycle while it gathers a message. The
// first fragment of a message sets the expected count; fragments with a bad
// position or count, and duplicates of a slot already held, are dropped
// without a response. When the last missing fragment arrives, intake stops:
// a read state starts the payload memory read, then one stored payload is
// presented per cycle in slot order while the output is not stalled, with
// the final one marked last. The drain uses the single read port of the
// payload memory. Intake reopens as soon as the final response is loaded
// into the output register, so the next message can start while that
// transfer is still pending. No clearing pass is needed after reset.
`default_nettype none

module fragment_reassembly_buffer
   import frb_pkg::*;
#(
   parameter int MAX_FRAGMENTS = FRB_MAX_FRAGMENTS
)(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   input  frb_req_type req_data,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output frb_rsp_type rsp_data
);

   frb_cmd_type    cmd;
   frb_status_type status;

   frb_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   frb_datapath #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

>>> hw/rtl/frb_checker.sv
// Port-level checker for the fragment reassembly buffer and its bind.
// Watches the top level's channels only; depends on frb_pkg.
`default_nettype none

module frb_checker
   import frb_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   input wire logic   req_valid,
   input wire logic   req_stall,
   input frb_req_type req_data,
   input wire logic   rsp_valid,
   input wire logic   rsp_stall,
   input frb_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response changed or dropped.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid right after reset.");

   a_drain_blocks_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> req_stall)
      else $error("Fragment intake open while a message drains.");

   a_drain_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=>
         rsp_valid && (rsp_data.slot_index == $past(rsp_data.slot_index) + 4'd1))
      else $error("Drain skipped a slot or paused.");

endmodule

bind fragment_reassembly_buffer frb_checker u_frb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
